[sv/mvt_pkg.sv]
// Shared types and constants for the matrix-vector transform block.
package mvt_pkg;

  localparam int unsigned LANES  = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned DIM_W  = 3;
  localparam int unsigned IDX_W  = 4;

  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;
  localparam logic [DIM_W-1:0] DIM_MIN   = 3'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  localparam data_t SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam data_t SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] entry_index;
    data_t            entry_value;
    data_t            vec_0;
    data_t            vec_1;
    data_t            vec_2;
    data_t            vec_3;
  } in_beat_t;

  typedef struct packed {
    data_t res_0;
    data_t res_1;
    data_t res_2;
    data_t res_3;
  } out_beat_t;

  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } lane_ctrl_t;

endpackage

[sv/mvt_lane.sv]
// One row lane: per-column multipliers, lane sum, shift and saturate.
module mvt_lane #(
  parameter int unsigned NCOL      = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  mvt_pkg::lane_ctrl_t ctrl_i,
  input  mvt_pkg::data_t     row_i [NCOL],
  input  mvt_pkg::data_t     vec_i [NCOL],
  input  logic [NCOL-1:0]    col_en_i,
  output mvt_pkg::data_t     res_o
);
  import mvt_pkg::*;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  prod_t prod_d [NCOL];
  prod_t prod_q [NCOL];
  sum_t  sum_d;
  sum_t  sum_q;
  sum_t  shifted;
  logic  fits;

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      prod_d[c] = row_i[c] * vec_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      for (int c = 0; c < NCOL; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  // columns past the active dimension drop out
  always_comb begin
    sum_d = '0;
    for (int c = 0; c < NCOL; c++) begin
      if (col_en_i[c]) begin
        sum_d = sum_d + sum_t'(prod_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      sum_q <= sum_d;
    end
  end

  assign shifted = sum_q >>> FRAC_BITS;
  assign fits    = (&shifted[SUM_W-1:DATA_W-1]) | ~(|shifted[SUM_W-1:DATA_W-1]);

  always_comb begin
    if (fits) begin
      res_o = shifted[DATA_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_o = SAT_MIN;
    end else begin
      res_o = SAT_MAX;
    end
  end

endmodule

[sv/mvt_merge.sv]
// Merge stage: gathers lane results, zeroes inactive rows, holds the output beat.
module mvt_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  mvt_pkg::data_t            res_i [mvt_pkg::LANES],
  input  logic [mvt_pkg::LANES-1:0] row_en_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mvt_pkg::out_beat_t        out_data_o
);
  import mvt_pkg::*;

  logic      valid_q;
  logic      valid_d;
  data_t     res_m [LANES];
  out_beat_t data_q;

  assign take_o  = valid_i && (!valid_q || !out_stall_i);
  assign valid_d = take_o || (valid_q && out_stall_i);

  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      res_m[r] = row_en_i[r] ? res_i[r] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      data_q.res_0 <= res_m[0];
      data_q.res_1 <= res_m[1];
      data_q.res_2 <= res_m[2];
      data_q.res_3 <= res_m[3];
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/matrix_vector_transform_core.sv]
// A transform beat passes the product, lane-sum and output registers before it is presented at the output.
// Throughput: one beat per cycle; stages only stall when the output is held.
// Path: multipliers (reg), lane sum (reg), shift/saturate + row merge (output reg).
// Load beats write the matrix at acceptance and yield no result beat.
// Reset (async, active low) clears the matrix to zero and sets dimension to 4.
module matrix_vector_transform_core #(
  parameter int unsigned MAX_DIM   = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mvt_pkg::in_beat_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mvt_pkg::out_beat_t        out_data_o,
  input  logic                      cfg_we_i,
  input  logic [mvt_pkg::DIM_W-1:0] cfg_data_i
);
  import mvt_pkg::*;

  // Rows/columns stored: MAX_DIM, but at most the 4 that the 4-bit entry index can reach.
  localparam int unsigned NR = (MAX_DIM < LANES) ? MAX_DIM : LANES;

  // Dimension register and its clamped form.
  logic [DIM_W-1:0] dim_q;
  logic [DIM_W-1:0] d_act;
  logic [LANES-1:0] row_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      dim_q <= cfg_data_i;
    end
  end

  always_comb begin
    priority if (dim_q < DIM_MIN) begin
      d_act = DIM_MIN;
    end else if (dim_q > DIM_W'(NR)) begin
      d_act = DIM_W'(NR);
    end else begin
      d_act = dim_q;
    end
  end

  // row r (and column r) takes part only below the active dimension
  always_comb begin
    for (int r = 0; r < LANES; r++) begin
      row_en[r] = DIM_W'(r) < d_act;
    end
  end

  // Pipeline control. v1: products held, v2: lane sums held.
  logic v1_q;
  logic v2_q;
  logic take;
  logic adv2;
  logic in_acc;
  logic ld_en;
  logic xf_en;
  lane_ctrl_t lane_ctrl;

  assign adv2       = v1_q && (!v2_q || take);
  assign in_stall_o = !(!v1_q || !v2_q || take);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ld_en      = in_acc && (in_data_i.op == OP_LOAD);
  assign xf_en      = in_acc && (in_data_i.op == OP_XFORM);

  assign lane_ctrl.prod_en = xf_en;
  assign lane_ctrl.sum_en  = adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= xf_en || (v1_q && !adv2);
      v2_q <= adv2 || (v2_q && !take);
    end
  end

  // Matrix store. A transform multiplies against the matrix as it stands at
  // its own acceptance, so later loads never disturb beats in flight.
  data_t      m_q [NR][NR];
  logic [1:0] idx_row;
  logic [1:0] idx_col;

  assign idx_row = in_data_i.entry_index[3:2];
  assign idx_col = in_data_i.entry_index[1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NR; c++) begin
          m_q[r][c] <= '0;
        end
      end
    end else if (ld_en) begin
      // entries outside the stored square match no slot and are dropped
      for (int r = 0; r < NR; r++) begin
        for (int c = 0; c < NR; c++) begin
          if (idx_row == 2'(r) && idx_col == 2'(c)) begin
            m_q[r][c] <= in_data_i.entry_value;
          end
        end
      end
    end
  end

  // Vector fan-out to the lanes.
  data_t vec_all [LANES];
  data_t vec_w   [NR];
  data_t lane_res [LANES];

  assign vec_all[0] = in_data_i.vec_0;
  assign vec_all[1] = in_data_i.vec_1;
  assign vec_all[2] = in_data_i.vec_2;
  assign vec_all[3] = in_data_i.vec_3;

  for (genvar c = 0; c < NR; c++) begin : g_vec
    assign vec_w[c] = vec_all[c];
  end

  // One lane per stored row.
  for (genvar r = 0; r < NR; r++) begin : g_lane
    mvt_lane #(
      .NCOL      (NR),
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .ctrl_i   (lane_ctrl),
      .row_i    (m_q[r]),
      .vec_i    (vec_w),
      .col_en_i (row_en[NR-1:0]),
      .res_o    (lane_res[r])
    );
  end

  // rows with no lane always read zero
  for (genvar r = NR; r < LANES; r++) begin : g_nolane
    assign lane_res[r] = '0;
  end

  mvt_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (v2_q),
    .res_i       (lane_res),
    .row_en_i    (row_en),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/mvt_checker.sv]
// Port-level checker for the matrix-vector transform core, with its bind.
module mvt_port_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input mvt_pkg::in_beat_t         in_data_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input mvt_pkg::out_beat_t        out_data_o,
  input logic                      cfg_we_i,
  input logic [mvt_pkg::DIM_W-1:0] cfg_data_i
);
  import mvt_pkg::*;

  logic xf_acc;
  assign xf_acc = in_valid_i && !in_stall_o && (in_data_i.op == OP_XFORM);

  // no result beat straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result beat right after reset");

  // an accepted transform is presented at the output when the sink keeps taking
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xf_acc ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("transform beat did not reach the output in time");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result beat dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result beat changed");

endmodule

bind matrix_vector_transform_core mvt_port_checker u_mvt_checker (.*);

[test/mvt_checker.sv]
// Checker for the matrix-vector transform: predicts result beats and compares them.
`timescale 1ns / 1ps
module mvt_checker #(
  parameter int unsigned MAX_DIM   = 4,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_stall_i,
  input  mvt_pkg::in_beat_t         in_data_i,
  input  logic                      out_valid_i,
  input  logic                      out_stall_i,
  input  mvt_pkg::out_beat_t        out_data_i,
  input  logic                      cfg_we_i,
  input  logic [mvt_pkg::DIM_W-1:0] cfg_data_i,
  output int unsigned               pending_o,
  output int unsigned               errors_o,
  output int unsigned               checked_o
);
  import mvt_pkg::*;

  localparam int unsigned TOP_DIM = (MAX_DIM < LANES) ? MAX_DIM : LANES;

  data_t            matrix_q [LANES*LANES];
  logic [DIM_W-1:0] dim_q;
  out_beat_t        expected_products [$];
  int unsigned      fail_count;
  int unsigned      match_count;

  // Matrix times vector over the active size, full-width sum, floor shift, saturate.
  function automatic out_beat_t predict_product(input in_beat_t beat);
    data_t                   vec [LANES];
    data_t                   res [LANES];
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] m;
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    int unsigned             n;
    out_beat_t               o;
    vec[0] = beat.vec_0;
    vec[1] = beat.vec_1;
    vec[2] = beat.vec_2;
    vec[3] = beat.vec_3;
    hi_lim = SAT_MAX;
    lo_lim = SAT_MIN;
    n = dim_q;
    if (n < DIM_MIN) n = DIM_MIN;
    if (n > TOP_DIM) n = TOP_DIM;
    for (int r = 0; r < LANES; r++) begin
      res[r] = '0;
      if (r < n) begin
        acc = '0;
        for (int c = 0; c < n; c++) begin
          m = matrix_q[r*LANES+c];
          x = vec[c];
          acc = acc + m * x;
        end
        acc = acc >>> FRAC_BITS;
        if (acc > hi_lim) res[r] = SAT_MAX;
        else if (acc < lo_lim) res[r] = SAT_MIN;
        else res[r] = acc[DATA_W-1:0];
      end
    end
    o.res_0 = res[0];
    o.res_1 = res[1];
    o.res_2 = res[2];
    o.res_3 = res[3];
    return o;
  endfunction

  task automatic check_field(input string name, input data_t want, input data_t got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_beat_t   want;
    int unsigned row;
    int unsigned col;
    if (!rst_ni) begin
      for (int i = 0; i < LANES*LANES; i++) matrix_q[i] = '0;
      dim_q = DIM_RESET;
      expected_products.delete();
      fail_count = 0;
      match_count = 0;
      pending_o <= 0;
      errors_o <= 0;
      checked_o <= 0;
    end else begin
      // result side first, so a beat can never match an expectation born this edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_products.size() == 0) begin
          $error("result beat with no transform outstanding: %p", out_data_i);
          fail_count++;
        end else begin
          want = expected_products.pop_front();
          check_field("res_0", want.res_0, out_data_i.res_0);
          check_field("res_1", want.res_1, out_data_i.res_1);
          check_field("res_2", want.res_2, out_data_i.res_2);
          check_field("res_3", want.res_3, out_data_i.res_3);
          match_count++;
        end
      end
      if (cfg_we_i) dim_q = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (in_data_i.op == OP_LOAD) begin
          row = in_data_i.entry_index >> 2;
          col = in_data_i.entry_index & 4'd3;
          if (row < MAX_DIM && col < MAX_DIM) matrix_q[row*LANES+col] = in_data_i.entry_value;
        end else begin
          expected_products.push_back(predict_product(in_data_i));
        end
      end
      pending_o <= expected_products.size();
      errors_o <= fail_count;
      checked_o <= match_count;
    end
  end

endmodule

[test/tb.sv]
// Testbench top: drives load/transform beats and dimension writes, reports the verdict.
`timescale 1ns / 1ps
module tb;
  import mvt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BEATS = 140;
  localparam int unsigned PHASES      = 9;
  // dimension codes used after the reset phase, phase 1 in the low bits
  localparam logic [8*DIM_W-1:0] DIM_PLAN =
    {3'd4, 3'd6, 3'd5, 3'd1, 3'd7, 3'd0, 3'd3, 3'd2};

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid;
  logic             in_stall;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [DIM_W-1:0] cfg_data;

  int unsigned pending;
  int unsigned mismatches;
  int unsigned checked;
  int unsigned cycles = 0;
  int unsigned n_loads;
  int unsigned n_xforms;
  int unsigned hold_left = 0;
  logic        quiet;

  matrix_vector_transform_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data)
  );

  mvt_checker product_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (mismatches),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles with %0d results outstanding", cycles, pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver back-pressure: random stall bursts between free-running stretches.
  always @(posedge clk_i) begin
    if (quiet || !rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      hold_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
      hold_left <= $urandom_range(0, 12);
    end
  end

  // Small Q16.16 values so sums stay in range, plus extremes and raw words.
  function automatic data_t rand_word();
    case ($urandom_range(0, 9))
      0:          return SAT_MAX;
      1:          return SAT_MIN;
      2, 3, 4, 5: return data_t'($urandom_range(0, 32'h0008_0000) - 32'h0004_0000);
      default:    return data_t'($urandom);
    endcase
  endfunction

  // Unused fields of a beat are randomized as well.
  function automatic in_beat_t rand_beat(input op_e op);
    in_beat_t b;
    b.op          = op;
    b.entry_index = IDX_W'($urandom_range(0, 15));
    b.entry_value = rand_word();
    b.vec_0       = rand_word();
    b.vec_1       = rand_word();
    b.vec_2       = rand_word();
    b.vec_3       = rand_word();
    return b;
  endfunction

  // Called at a rising edge; returns at the edge where the beat was taken.
  // Stall is sampled at the falling edge, where it is settled for the next edge.
  task automatic send_beat(input in_beat_t beat);
    logic stalled;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    if (beat.op == OP_LOAD) n_loads++;
    else n_xforms++;
  endtask

  // Hold the sender until every transform has come back, then let the pipe settle.
  task automatic drain(input int unsigned tail);
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  initial begin : stimulus
    in_beat_t    b;
    int unsigned k;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    quiet     = 1'b0;
    n_loads   = 0;
    n_xforms  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: the cleared matrix must give zeros, even for full-scale input.
    b = rand_beat(OP_XFORM);
    b.vec_0 = SAT_MAX; b.vec_1 = SAT_MAX; b.vec_2 = SAT_MAX; b.vec_3 = SAT_MAX;
    send_beat(b);
    // Rows: all max, all min, all -1 LSB, all 1.0.
    for (k = 0; k < 16; k++) begin
      b = rand_beat(OP_LOAD);
      b.entry_index = IDX_W'(k);
      case (k >> 2)
        0:       b.entry_value = SAT_MAX;
        1:       b.entry_value = SAT_MIN;
        2:       b.entry_value = -32'sd1;
        default: b.entry_value = 32'sh0001_0000;
      endcase
      send_beat(b);
    end
    // Positive and negative saturation, including min*min summed past 64 bits.
    b = rand_beat(OP_XFORM);
    b.vec_0 = SAT_MAX; b.vec_1 = SAT_MAX; b.vec_2 = SAT_MAX; b.vec_3 = SAT_MAX;
    send_beat(b);
    b.vec_0 = SAT_MIN; b.vec_1 = SAT_MIN; b.vec_2 = SAT_MIN; b.vec_3 = SAT_MIN;
    send_beat(b);
    // Tiny negative sum: the shift must floor toward minus infinity.
    b.vec_0 = 32'sd1; b.vec_1 = 32'sd1; b.vec_2 = 32'sd1; b.vec_3 = 32'sd1;
    send_beat(b);
    b.vec_0 = SAT_MAX; b.vec_1 = SAT_MIN; b.vec_2 = 32'sd1; b.vec_3 = -32'sd1;
    send_beat(b);

    // Random phases, one per dimension code; each write waits for an empty pipe.
    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        drain(6);
        cfg_we   <= 1'b1;
        cfg_data <= DIM_PLAN[(p-1)*DIM_W +: DIM_W];
        @(posedge clk_i);
        cfg_we <= 1'b0;
      end
      quiet <= (p == PHASES - 1);
      // fresh matrix first, then a mix that leans on transforms
      for (k = 0; k < 16; k++) begin
        b = rand_beat(OP_LOAD);
        b.entry_index = IDX_W'(k);
        send_beat(b);
      end
      for (k = 16; k < PHASE_BEATS; k++) begin
        send_beat(rand_beat(($urandom_range(0, 3) == 0) ? OP_LOAD : OP_XFORM));
      end
    end

    drain(8);
    $display("covered %0d load and %0d transform beats over dimension codes 4,2,3,0,7,1,5,6,4",
             n_loads, n_xforms);
    $display("%0d result beats compared field by field, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
